// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the time set editor.
// No dependencies; included by the files that hold concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CTSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CTSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ctse_pkg.sv =====
// Package for the clock time set editor: item types, codes and small lookups.
// No dependencies; imported by clock_time_set_editor_unit.
`default_nettype none

package ctse_pkg;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_INC    = 3'd1;
   localparam logic [2:0] ACT_DEC    = 3'd2;
   localparam logic [2:0] ACT_NEXT   = 3'd3;
   localparam logic [2:0] ACT_CANCEL = 3'd4;
   localparam logic [2:0] ACT_LOAD   = 3'd5;

   localparam logic [2:0] PH_YEAR     = 3'd0;
   localparam logic [2:0] PH_MONTH    = 3'd1;
   localparam logic [2:0] PH_DAY      = 3'd2;
   localparam logic [2:0] PH_HOUR     = 3'd3;
   localparam logic [2:0] PH_MINUTE   = 3'd4;
   localparam logic [2:0] PH_SECOND   = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;
   localparam logic [2:0] PH_CANCELED = 3'd7;

   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINSEC_MAX = 6'd59;
   localparam logic [4:0] FEB_MIN    = 5'd28;
   localparam logic [4:0] FEB_MAX    = 5'd29;
   localparam logic [4:0] FEB_RESET  = 5'd28;

   typedef struct packed {
      logic [2:0] action;
      logic [6:0] load_years;
      logic [3:0] load_months;
      logic [4:0] load_days;
      logic [4:0] load_hours;
      logic [5:0] load_minutes;
      logic [5:0] load_seconds;
   } ctse_req_type;

   typedef struct packed {
      logic [2:0] edit_phase;
      logic [6:0] shown_years;
      logic [3:0] shown_months;
      logic [4:0] shown_days;
      logic [4:0] shown_hours;
      logic [5:0] shown_minutes;
      logic [5:0] shown_seconds;
      logic       value_changed;
      logic [3:0] cursor_col;
      logic       cursor_row;
   } ctse_rsp_type;

   // Length of a month; codes outside 1..12 behave as January.
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic [4:0] feb);
      logic [4:0] len;
      case (m) inside
         4'd2:                    len = feb;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Wrapping step inside lo..hi; a value above hi steps down to hi.
   function automatic logic [6:0] step_val(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi, input logic up);
      logic [6:0] r;
      if (up) begin
         r = (v >= hi) ? lo : v + 7'd1;
      end else if (v <= lo) begin
         r = hi;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v - 7'd1;
      end
      return r;
   endfunction

   function automatic logic [3:0] cursor_col_of(input logic [2:0] ph);
      logic [3:0] c;
      case (ph)
         PH_MONTH, PH_MINUTE: c = 4'd7;
         PH_DAY, PH_SECOND:   c = 4'd4;
         default:             c = 4'd10;
      endcase
      return c;
   endfunction

   function automatic logic cursor_row_of(input logic [2:0] ph);
      return (ph == PH_HOUR) || (ph == PH_MINUTE) || (ph == PH_SECOND) ? 1'b0 : 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/clock_time_set_editor_unit.sv =====
// Top level of the clock time set editor: date/time state, field editing and item handshakes.
// Depends on ctse_pkg and assert_macros.svh.
//
// Keypad editor for a date and time. Each accepted item (none, increment, decrement, next
// field, cancel, or load) gives exactly one result carrying the edit phase, all six values,
// a change flag and the display cursor of the edited field. The block takes one item per
// cycle while the input is not held off: an accepted item lands in the input register, and
// once the result register is free or being taken, the state update and result are computed
// in a single pass into the result register, from which the result is offered. The input is
// held off only while the input register holds an item that cannot move because the result
// register is full and stalled. The February length register is written through
// csr_wr_en/csr_wr_data and clamps to 28..29 on use.
`default_nettype none
`include "assert_macros.svh"

module clock_time_set_editor_unit
   import ctse_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire ctse_req_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      ctse_rsp_type rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [4:0]   csr_wr_data
);

   logic         in_valid_ff, in_valid_in;
   ctse_req_type req_ff;
   logic         out_valid_ff, out_valid_in;
   ctse_rsp_type rsp_ff, rsp_in;
   logic         advance;

   logic [4:0] feb_ff;
   logic [2:0] phase_ff, phase_in;
   logic [6:0] years_ff, years_in;
   logic [3:0] months_ff, months_in;
   logic [4:0] days_ff, days_in;
   logic [4:0] hours_ff, hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic       changed;

   assign advance      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~advance;
   assign in_valid_in  = (req_valid & ~req_stall) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = rsp_ff;

   always_comb begin
      logic [4:0] feb_len;
      logic [3:0] ld_month;
      logic [4:0] ld_len;
      logic [4:0] cur_len;
      logic       up;
      logic [6:0] stepped;
      feb_len = (feb_ff < FEB_MIN) ? FEB_MIN : ((feb_ff > FEB_MAX) ? FEB_MAX : feb_ff);
      ld_month = (req_ff.load_months == 4'd0) ? 4'd1 :
                 ((req_ff.load_months > MONTH_MAX) ? MONTH_MAX : req_ff.load_months);
      ld_len  = month_days(ld_month, feb_len);
      cur_len = month_days(months_ff, feb_len);
      up      = (req_ff.action == ACT_INC);
      stepped = 7'd0;

      phase_in   = phase_ff;
      years_in   = years_ff;
      months_in  = months_ff;
      days_in    = days_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      changed    = 1'b0;

      if (req_ff.action == ACT_LOAD) begin
         years_in  = (req_ff.load_years > YEAR_MAX) ? YEAR_MAX : req_ff.load_years;
         months_in = ld_month;
         days_in   = (req_ff.load_days == 5'd0) ? 5'd1 :
                     ((req_ff.load_days > ld_len) ? ld_len : req_ff.load_days);
         hours_in  = (req_ff.load_hours > HOUR_MAX) ? HOUR_MAX : req_ff.load_hours;
         minutes_in = (req_ff.load_minutes > MINSEC_MAX) ? MINSEC_MAX : req_ff.load_minutes;
         seconds_in = (req_ff.load_seconds > MINSEC_MAX) ? MINSEC_MAX : req_ff.load_seconds;
         phase_in  = PH_YEAR;
      end else if (req_ff.action == ACT_CANCEL) begin
         phase_in = PH_CANCELED;
      end else if (phase_ff == PH_CANCELED) begin
         if (req_ff.action != ACT_NEXT) begin
            phase_in = PH_YEAR;
         end
      end else if (phase_ff == PH_DONE) begin
         phase_in = PH_DONE;
      end else if (req_ff.action == ACT_NEXT) begin
         phase_in = phase_ff + 3'd1;
      end else if (req_ff.action == ACT_INC || req_ff.action == ACT_DEC) begin
         changed = 1'b1;
         unique case (phase_ff)
            PH_YEAR: begin
               years_in = step_val(years_ff, 7'd0, YEAR_MAX, up);
            end
            PH_MONTH: begin
               stepped   = step_val({3'd0, months_ff}, 7'd1, {3'd0, MONTH_MAX}, up);
               months_in = stepped[3:0];
            end
            PH_DAY: begin
               stepped = step_val({2'd0, days_ff}, 7'd1, {2'd0, cur_len}, up);
               days_in = stepped[4:0];
            end
            PH_HOUR: begin
               stepped  = step_val({2'd0, hours_ff}, 7'd0, {2'd0, HOUR_MAX}, up);
               hours_in = stepped[4:0];
            end
            PH_MINUTE: begin
               stepped    = step_val({1'b0, minutes_ff}, 7'd0, {1'b0, MINSEC_MAX}, up);
               minutes_in = stepped[5:0];
            end
            default: begin
               stepped    = step_val({1'b0, seconds_ff}, 7'd0, {1'b0, MINSEC_MAX}, up);
               seconds_in = stepped[5:0];
            end
         endcase
      end

      rsp_in.edit_phase    = phase_in;
      rsp_in.shown_years   = years_in;
      rsp_in.shown_months  = months_in;
      rsp_in.shown_days    = days_in;
      rsp_in.shown_hours   = hours_in;
      rsp_in.shown_minutes = minutes_in;
      rsp_in.shown_seconds = seconds_in;
      rsp_in.value_changed = changed;
      rsp_in.cursor_col    = cursor_col_of(phase_in);
      rsp_in.cursor_row    = cursor_row_of(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         feb_ff       <= FEB_RESET;
         phase_ff     <= PH_YEAR;
         years_ff     <= 7'd0;
         months_ff    <= 4'd1;
         days_ff      <= 5'd1;
         hours_ff     <= 5'd0;
         minutes_ff   <= 6'd0;
         seconds_ff   <= 6'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            feb_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff   <= phase_in;
            years_ff   <= years_in;
            months_ff  <= months_in;
            days_ff    <= days_in;
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
         end
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `CTSE_ASSERT_NXT(a_item_moves, clock, reset, in_valid_ff && !out_valid_ff,
                    out_valid_ff, "held item did not reach the free result register")
   `CTSE_ASSERT_IMP(a_change_phase, clock, reset, rsp_valid && rsp_data.value_changed,
                    rsp_data.edit_phase != PH_DONE && rsp_data.edit_phase != PH_CANCELED,
                    "value changed outside a field phase")
   `CTSE_ASSERT_IMP(a_month_range, clock, reset, 1'b1,
                    months_ff >= 4'd1 && months_ff <= MONTH_MAX && days_ff != 5'd0,
                    "month or day left its range")
   `CTSE_ASSERT_IMP(a_end_cursor, clock, reset,
                    rsp_valid && (rsp_data.edit_phase == PH_DONE ||
                                  rsp_data.edit_phase == PH_CANCELED),
                    rsp_data.cursor_col == 4'd10 && rsp_data.cursor_row,
                    "cursor wrong in done or canceled")

endmodule

`default_nettype wire

// ===== tb/tb_clock_time_set_editor_unit.sv =====
// Self-checking testbench for clock_time_set_editor_unit: keypad items in, display results out.
// Needs ctse_pkg for the item types and codes; predicts every result and compares it in order.
`timescale 1ns / 1ps

module tb_clock_time_set_editor_unit;
   import ctse_pkg::*;

   // Codes 6 and 7 have no meaning and must behave as no key at all.
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam int HOLD_CYCLES = 120;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ctse_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ctse_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = 5'd0;

   clock_time_set_editor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted copy of the editor's state and the February register.
   logic [4:0] feb_setting;
   logic [2:0] held_phase;
   logic [6:0] held_years;
   logic [3:0] held_months;
   logic [4:0] held_days;
   logic [4:0] held_hours;
   logic [5:0] held_minutes;
   logic [5:0] held_seconds;

   ctse_rsp_type predicted_screens[$];
   int mismatch_count = 0;
   int keys_sent = 0;
   int quiet_cycles = 0;
   bit req_gaps_on = 1'b1;
   logic rsp_gaps_on = 1'b1;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   function automatic int february_length();
      if (feb_setting < FEB_MIN) return FEB_MIN;
      if (feb_setting > FEB_MAX) return FEB_MAX;
      return feb_setting;
   endfunction

   function automatic int month_length(input int month);
      case (month)
         2:           return february_length();
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic int limit_value(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // A value left above its limit by a month change wraps up to lo and steps down to the limit.
   function automatic int wrap_value(input int v, input int lo, input int hi, input bit up);
      if (up) return (v >= hi) ? lo : v + 1;
      if (v <= lo || v > hi) return hi;
      return v - 1;
   endfunction

   task automatic reset_prediction();
      feb_setting = FEB_RESET;
      held_phase = PH_YEAR;
      held_years = 7'd0;
      held_months = 4'd1;
      held_days = 5'd1;
      held_hours = 5'd0;
      held_minutes = 6'd0;
      held_seconds = 6'd0;
   endtask

   function automatic ctse_rsp_type apply_keypress(input ctse_req_type item);
      ctse_rsp_type screen;
      bit up;
      bit changed;
      changed = 1'b0;
      up = (item.action == ACT_INC);
      if (item.action == ACT_LOAD) begin
         held_years = 7'(limit_value(item.load_years, 0, YEAR_MAX));
         held_months = 4'(limit_value(item.load_months, 1, MONTH_MAX));
         held_days = 5'(limit_value(item.load_days, 1, month_length(held_months)));
         held_hours = 5'(limit_value(item.load_hours, 0, HOUR_MAX));
         held_minutes = 6'(limit_value(item.load_minutes, 0, MINSEC_MAX));
         held_seconds = 6'(limit_value(item.load_seconds, 0, MINSEC_MAX));
         held_phase = PH_YEAR;
      end else if (item.action == ACT_CANCEL) begin
         held_phase = PH_CANCELED;
      end else if (held_phase == PH_CANCELED) begin
         if (item.action != ACT_NEXT) held_phase = PH_YEAR;
      end else if (held_phase == PH_DONE) begin
         // Only cancel or load leave the done phase.
      end else if (item.action == ACT_NEXT) begin
         held_phase = held_phase + 3'd1;
      end else if (item.action == ACT_INC || item.action == ACT_DEC) begin
         changed = 1'b1;
         case (held_phase)
            PH_YEAR:   held_years = 7'(wrap_value(held_years, 0, YEAR_MAX, up));
            PH_MONTH:  held_months = 4'(wrap_value(held_months, 1, MONTH_MAX, up));
            PH_DAY:    held_days = 5'(wrap_value(held_days, 1, month_length(held_months), up));
            PH_HOUR:   held_hours = 5'(wrap_value(held_hours, 0, HOUR_MAX, up));
            PH_MINUTE: held_minutes = 6'(wrap_value(held_minutes, 0, MINSEC_MAX, up));
            default:   held_seconds = 6'(wrap_value(held_seconds, 0, MINSEC_MAX, up));
         endcase
      end
      screen.edit_phase = held_phase;
      screen.shown_years = held_years;
      screen.shown_months = held_months;
      screen.shown_days = held_days;
      screen.shown_hours = held_hours;
      screen.shown_minutes = held_minutes;
      screen.shown_seconds = held_seconds;
      screen.value_changed = changed;
      // Date fields sit on row 1 and time fields on row 0, at columns 10, 7 and 4.
      if (held_phase < PH_DONE) begin
         screen.cursor_col = 4'd10 - 4'd3 * (held_phase % 3);
         screen.cursor_row = (held_phase < PH_HOUR);
      end else begin
         screen.cursor_col = 4'd10;
         screen.cursor_row = 1'b1;
      end
      return screen;
   endfunction

   function automatic ctse_req_type random_key();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(ctse_req_type)-1:0];
   endfunction

   function automatic ctse_req_type key_of(input logic [2:0] action);
      ctse_req_type item;
      item = random_key();
      item.action = action;
      return item;
   endfunction

   function automatic ctse_req_type load_of(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s);
      ctse_req_type item;
      item.action = ACT_LOAD;
      item.load_years = 7'(y);
      item.load_months = 4'(mo);
      item.load_days = 5'(d);
      item.load_hours = 5'(h);
      item.load_minutes = 6'(mi);
      item.load_seconds = 6'(s);
      return item;
   endfunction

   function automatic logic [2:0] pick_edit_action();
      int r;
      r = $urandom_range(9);
      if (r < 4) return ACT_INC;
      if (r < 8) return ACT_DEC;
      if (r == 8) return ACT_NONE;
      return ACT_SPARE_7;
   endfunction

   task automatic send_item(input ctse_req_type item);
      int gap;
      gap = 0;
      while (req_gaps_on && $urandom_range(99) < 10) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_screens.push_back(apply_keypress(item));
      keys_sent++;
   endtask

   task automatic send_key(input logic [2:0] action);
      send_item(key_of(action));
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (predicted_screens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_february(input logic [4:0] days);
      wait_for_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= days;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      feb_setting = days;
   endtask

   // Mostly load a time, give each field a few edits, play in done and at times canceled.
   task automatic run_edit_session();
      if ($urandom_range(9) == 0) begin
         send_item(random_key());
      end else begin
         send_item(load_of($urandom_range(99), $urandom_range(1, 12), $urandom_range(1, 31),
                           $urandom_range(23), $urandom_range(59), $urandom_range(59)));
      end
      for (int f = 0; f < 6; f++) begin
         repeat ($urandom_range(0, 4)) send_key(pick_edit_action());
         send_key(ACT_NEXT);
      end
      repeat ($urandom_range(0, 2)) send_key(3'($urandom_range(ACT_NONE, ACT_NEXT)));
      if ($urandom_range(2) == 0) begin
         send_key(ACT_CANCEL);
         repeat ($urandom_range(0, 2)) send_key(3'($urandom_range(7)));
      end
   endtask

   task automatic test_directed_walk();
      send_key(ACT_NONE);
      send_key(ACT_DEC);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_SPARE_6);
      send_key(ACT_CANCEL);
      send_key(ACT_NEXT);
      send_key(ACT_CANCEL);
      send_key(ACT_DEC);
      send_key(ACT_CANCEL);
      send_key(ACT_INC);
      send_key(ACT_CANCEL);
      send_key(ACT_SPARE_7);
      send_item(load_of(127, 15, 31, 31, 63, 63));
      send_item(load_of(0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_february_length();
      write_february(5'd29);
      send_item(load_of(24, 2, 31, 12, 30, 30));
      send_key(ACT_NEXT);
      send_key(ACT_NEXT);
      send_key(ACT_INC);
      send_key(ACT_DEC);
      // Below 28 the register acts as 28; day 31 is left above February's length.
      write_february(5'd0);
      send_item(load_of(50, 1, 31, 1, 1, 1));
      send_key(ACT_NEXT);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_INC);
      send_item(load_of(50, 1, 31, 1, 1, 1));
      send_key(ACT_NEXT);
      send_key(ACT_INC);
      send_key(ACT_NEXT);
      send_key(ACT_DEC);
      write_february(5'd31);
      send_item(load_of(99, 2, 30, 23, 59, 59));
      write_february(5'd28);
      send_item(load_of(1, 2, 29, 0, 0, 0));
      send_item(load_of(2, 4, 31, 0, 0, 0));
   endtask

   task automatic test_result_backpressure();
      wait_for_quiet();
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      hold_requests <= hold_requests + 1;
      run_edit_session();
      run_edit_session();
      wait_for_quiet();
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   task automatic test_random_sessions(input int item_count);
      logic [4:0] feb_picks [6] = '{5'd28, 5'd29, 5'd0, 5'd31, 5'd27, 5'd30};
      int stop_at;
      int next_write;
      stop_at = keys_sent + item_count;
      next_write = keys_sent + 250;
      while (keys_sent < stop_at) begin
         run_edit_session();
         repeat ($urandom_range(0, 2)) send_item(random_key());
         if (keys_sent >= next_write) begin
            write_february(feb_picks[$urandom_range(5)]);
            next_write = keys_sent + 250;
         end
      end
   endtask

   task automatic test_steady_stream(input int item_count);
      int stop_at;
      wait_for_quiet();
      stop_at = keys_sent + item_count;
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      while (keys_sent < stop_at) run_edit_session();
      wait_for_quiet();
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      ctse_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_screens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result with nothing expected: %p", rsp_data);
         end else begin
            want = predicted_screens.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected %p", want);
                  $display("          actual   %p", rsp_data);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("clock_time_set_editor_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_prediction();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      test_february_length();
      test_result_backpressure();
      test_random_sessions(1400);
      test_steady_stream(200);
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_screens.size() == 0) begin
         $display("clock_time_set_editor_unit regression: pass");
      end else begin
         $display("clock_time_set_editor_unit regression: fail");
      end
      $finish;
   end

endmodule
